// ===== rtl/fst_pkg.sv =====
// ----------------------------------------------------------------------------
// fst_pkg
// Types and constants shared by the flow statistics table modules.
// ----------------------------------------------------------------------------
package fst_pkg;

	localparam int CELLS     = 4;
	localparam int CELL_BITS = 2;
	localparam int SLOT_W    = 20;
	localparam int COUNT_W   = 21;
	localparam int WIDE_W    = 22;

	localparam logic [31:0] GAP_START         = 32'd10000000;
	localparam logic [31:0] MICROS_PER_SECOND = 32'd1000000;
	localparam logic [7:0]  PROTO_TCP         = 8'd6;
	localparam logic [7:0]  PROTO_UDP         = 8'd17;
	localparam logic [15:0] MIN_IP_BYTES      = 16'd20;
	localparam logic [15:0] MIN_TCP_BYTES     = 16'd20;
	localparam logic [15:0] MIN_UDP_BYTES     = 16'd8;

	typedef enum logic [1:0] {
		ST_DROP   = 2'd0,
		ST_NEW    = 2'd1,
		ST_UPDATE = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef struct packed {
		logic [31:0] source_address;
		logic [31:0] dest_address;
		logic [15:0] source_port_raw;
		logic [15:0] dest_port_raw;
		logic [7:0]  ip_protocol;
		logic [3:0]  header_words;
		logic [15:0] total_length;
		logic [12:0] fragment_offset;
		logic [15:0] captured_ip_size;
		logic [31:0] stamp_seconds;
		logic [19:0] stamp_micros;
		logic [15:0] frame_length;
	} pkt_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [9:0]  flow_slot;
		logic [31:0] packet_total;
		logic [31:0] byte_total;
		logic [31:0] gap_micros;
		logic [47:0] gap_sum;
		logic [31:0] gap_least;
		logic [31:0] gap_most;
		logic [15:0] length_least;
		logic [15:0] length_most;
	} res_t;

	typedef struct packed {
		logic [63:0] addrs;
		logic [39:0] ports_proto;
		logic [51:0] stamp;
		logic [31:0] packets;
		logic [31:0] bytes;
		logic [47:0] gap_sum;
		logic [31:0] gap_least;
		logic [31:0] gap_most;
		logic [15:0] length_least;
		logic [15:0] length_most;
	} rec_t;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
		rec_t              rec;
	} chain_t;

endpackage

// ===== rtl/flow_statistics_table.sv =====
// ----------------------------------------------------------------------------
// flow_statistics_table
// Five-tuple flow metering table with per-flow packet, byte, gap and length
// statistics.
// ----------------------------------------------------------------------------
// The block takes one IPv4 header item at a time and returns one result item
// for it. Flow records live in a row of four banked cells; a lookup reads one
// row of all four banks per cycle and the hit travels down the cell chain.
// A dropped (malformed) item goes straight to the push state; any other item
// passes the scan, calc and push states. The scan reads at most ceil(F/4)
// rows, where F is the number of flows in use, and it ends early on a hit.
// There is no clearing pass after reset, as live entries are tracked by
// the fill count. One item is in flight at a time; the next item is
// accepted while the previous result still waits in the output register.
module flow_statistics_table import fst_pkg::*; #(
	parameter int FLOW_ENTRIES = 1024
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  pkt_valid,
	output logic  pkt_stall,
	input  pkt_t  pkt,
	output logic  res_valid,
	input  logic  res_stall,
	output res_t  res
);

	localparam int ROWS = (FLOW_ENTRIES + CELLS - 1) / CELLS;
	localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_CALC1 = 5'b00100,
		S_CALC2 = 5'b01000,
		S_PUSH  = 5'b10000
	} state_t;

	state_t             state_q;
	logic [COUNT_W-1:0] count_q;
	logic               pend_q;
	logic               res_valid_q;
	logic [RW:0]        row_q;

	pkt_t               item_q;
	logic [63:0]        addrs_q;
	logic [39:0]        pp_q;
	logic [51:0]        prod_q;
	logic [51:0]        now_q;
	logic               hit_q;
	rec_t               hit_rec_q;
	logic [SLOT_W-1:0]  hit_slot_q;
	rec_t               base_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [31:0]        gap_q;
	logic               fresh_q;
	res_t               res_q;
	res_t               out_q;

	logic               accept;
	logic [5:0]         hdr_bytes;
	logic [15:0]        l4_len;
	logic               malformed;
	logic               ports_ok;
	logic [COUNT_W-1:0] used_rows;
	logic               scan_hit;
	logic               issuing;
	logic               full;
	logic [51:0]        prev_time;
	logic [51:0]        diff;
	logic [31:0]        gap_c;
	rec_t               init_rec;
	rec_t               upd;
	logic [48:0]        sum_c;
	res_t               drop_res;
	res_t               full_res;
	res_t               done_res;
	logic               out_load;
	chain_t             chain_w [CELLS+1];

	assign pkt_stall = (state_q != S_IDLE);
	assign accept    = pkt_valid && !pkt_stall;
	assign res_valid = res_valid_q;
	assign res       = out_q;

	// Header checks on the incoming item.
	always_comb begin
		hdr_bytes = {pkt.header_words, 2'b00};
		l4_len    = pkt.total_length - 16'(hdr_bytes);
		malformed = (pkt.captured_ip_size < MIN_IP_BYTES) ||
			(16'(hdr_bytes) > pkt.captured_ip_size) ||
			(pkt.captured_ip_size < pkt.total_length) ||
			(pkt.fragment_offset != 13'd0);
		ports_ok  = ((pkt.ip_protocol == PROTO_TCP) && (l4_len >= MIN_TCP_BYTES)) ||
			((pkt.ip_protocol == PROTO_UDP) && (l4_len >= MIN_UDP_BYTES));
	end

	// The scan walks rows until a hit comes back or all used rows are read.
	always_comb begin
		used_rows = (count_q + COUNT_W'(CELLS - 1)) >> CELL_BITS;
		scan_hit  = pend_q && chain_w[CELLS].hit;
		issuing   = (state_q == S_SCAN) && !scan_hit &&
			(WIDE_W'(row_q) < WIDE_W'(used_rows));
		full      = !hit_q && (WIDE_W'(count_q) >= WIDE_W'(FLOW_ENTRIES));
	end

	// A backward time counts as no gap; a long gap saturates at 32 bits.
	always_comb begin
		prev_time = hit_q ? hit_rec_q.stamp : now_q;
		diff      = now_q - prev_time;
		if (now_q < prev_time) begin
			gap_c = 32'd0;
		end else if (|diff[51:32]) begin
			gap_c = 32'hFFFF_FFFF;
		end else begin
			gap_c = diff[31:0];
		end
		init_rec              = '0;
		init_rec.addrs        = addrs_q;
		init_rec.ports_proto  = pp_q;
		init_rec.stamp        = now_q;
		init_rec.gap_least    = GAP_START;
		init_rec.length_least = item_q.frame_length;
		init_rec.length_most  = item_q.frame_length;
	end

	// Statistics update of the selected record.
	always_comb begin
		upd         = base_q;
		upd.packets = base_q.packets + 32'd1;
		upd.bytes   = base_q.bytes + 32'(item_q.frame_length);
		sum_c       = {1'b0, base_q.gap_sum} + 49'(gap_q);
		upd.gap_sum = sum_c[48] ? 48'hFFFF_FFFF_FFFF : sum_c[47:0];
		if (!fresh_q) begin
			if (gap_q < base_q.gap_least) begin
				upd.gap_least = gap_q;
			end
			if (gap_q > base_q.gap_most) begin
				upd.gap_most = gap_q;
			end
		end
		if (item_q.frame_length < base_q.length_least) begin
			upd.length_least = item_q.frame_length;
		end
		if (item_q.frame_length > base_q.length_most) begin
			upd.length_most = item_q.frame_length;
		end
		upd.stamp = now_q;
	end

	// Result items: the two refusals carry only their status.
	always_comb begin
		drop_res              = '0;
		drop_res.status       = ST_DROP;
		full_res              = '0;
		full_res.status       = ST_FULL;
		done_res              = '0;
		done_res.status       = fresh_q ? ST_NEW : ST_UPDATE;
		done_res.flow_slot    = slot_q[9:0];
		done_res.packet_total = upd.packets;
		done_res.byte_total   = upd.bytes;
		done_res.gap_micros   = gap_q;
		done_res.gap_sum      = upd.gap_sum;
		done_res.gap_least    = upd.gap_least;
		done_res.gap_most     = upd.gap_most;
		done_res.length_least = upd.length_least;
		done_res.length_most  = upd.length_most;
	end

	assign out_load = (state_q == S_PUSH) && (!res_valid_q || !res_stall);

	assign chain_w[0] = '0;

	for (genvar c = 0; c < CELLS; c++) begin : g_cell
		fst_cell #(
			.CELL_ID (c),
			.ROWS    (ROWS),
			.RW      (RW)
		) u_cell (
			.clk       (clk),
			.rd_en     (issuing),
			.rd_row    (row_q[RW-1:0]),
			.key_addrs (addrs_q),
			.key_pp    (pp_q),
			.count     (count_q),
			.wr_en     ((state_q == S_CALC2) && (slot_q[CELL_BITS-1:0] == CELL_BITS'(c))),
			.wr_row    (slot_q[CELL_BITS+RW-1:CELL_BITS]),
			.wr_rec    (upd),
			.chain_i   (chain_w[c]),
			.chain_o   (chain_w[c+1])
		);
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			pend_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			pend_q <= issuing;
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= malformed ? S_PUSH : S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_hit || (!issuing && !pend_q)) begin
						state_q <= S_CALC1;
					end
				end
				S_CALC1: begin
					state_q <= full ? S_PUSH : S_CALC2;
				end
				S_CALC2: begin
					if (fresh_q) begin
						count_q <= count_q + COUNT_W'(1);
					end
					state_q <= S_PUSH;
				end
				S_PUSH: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= res_q;
		end
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					item_q  <= pkt;
					addrs_q <= {pkt.source_address, pkt.dest_address};
					pp_q    <= ports_ok ?
						{pkt.source_port_raw, pkt.dest_port_raw, pkt.ip_protocol} :
						{32'd0, pkt.ip_protocol};
					prod_q  <= 52'(pkt.stamp_seconds) * 52'(MICROS_PER_SECOND);
					row_q   <= '0;
					res_q   <= drop_res;
				end
			end
			S_SCAN: begin
				now_q <= prod_q + 52'(item_q.stamp_micros);
				if (issuing) begin
					row_q <= row_q + (RW+1)'(1);
				end
				hit_q <= scan_hit;
				if (scan_hit) begin
					hit_rec_q  <= chain_w[CELLS].rec;
					hit_slot_q <= chain_w[CELLS].slot;
				end
			end
			S_CALC1: begin
				if (full) begin
					res_q <= full_res;
				end
				fresh_q <= !hit_q;
				base_q  <= hit_q ? hit_rec_q : init_rec;
				slot_q  <= hit_q ? hit_slot_q : SLOT_W'(count_q);
				gap_q   <= gap_c;
			end
			S_CALC2: begin
				res_q <= done_res;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/fst_cell.sv =====
// ----------------------------------------------------------------------------
// fst_cell
// One bank of flow records. Reads one row per cycle, compares the stored key
// against the key under search and passes a hit down the chain.
// ----------------------------------------------------------------------------
module fst_cell import fst_pkg::*; #(
	parameter int CELL_ID = 0,
	parameter int ROWS    = 256,
	parameter int RW      = 8
) (
	input  logic               clk,
	input  logic               rd_en,
	input  logic [RW-1:0]      rd_row,
	input  logic [63:0]        key_addrs,
	input  logic [39:0]        key_pp,
	input  logic [COUNT_W-1:0] count,
	input  logic               wr_en,
	input  logic [RW-1:0]      wr_row,
	input  rec_t               wr_rec,
	input  chain_t             chain_i,
	output chain_t             chain_o
);

	rec_t          mem [ROWS];
	rec_t          rdata_q;
	logic [RW-1:0] row_q;
	logic [SLOT_W-1:0] slot;
	logic          hit;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_row] <= wr_rec;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_row];
			row_q   <= rd_row;
		end
	end

	// Slots are handed out in order, so an entry is live when its index is
	// below the number of flows in use.
	always_comb begin
		slot = (SLOT_W'(row_q) << CELL_BITS) | SLOT_W'(CELL_ID);
		hit  = (WIDE_W'(slot) < WIDE_W'(count)) && (rdata_q.addrs == key_addrs) &&
			(rdata_q.ports_proto == key_pp);
		if (hit) begin
			chain_o.hit  = 1'b1;
			chain_o.slot = slot;
			chain_o.rec  = rdata_q;
		end else begin
			chain_o = chain_i;
		end
	end

endmodule

// ===== rtl/fst_checker.sv =====
// ----------------------------------------------------------------------------
// fst_checker
// Port-level checks on the result items of the flow statistics table.
// ----------------------------------------------------------------------------
module fst_checker import fst_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input logic res_stall,
	input res_t res
);

	// A held result does not change while stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result changed");

	// Dropped and full-table results carry no record.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.status == ST_DROP || res.status == ST_FULL) |->
		res.flow_slot == 10'd0 && res.packet_total == 32'd0 && res.gap_sum == 48'd0)
		else $error("dropped result has nonzero fields");

	// A new flow starts with one packet, no gap and the initial least gap.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status == ST_NEW |->
		res.packet_total == 32'd1 && res.gap_micros == 32'd0 &&
		res.gap_least == GAP_START && res.length_least == res.length_most)
		else $error("new flow record malformed");

	// Length bounds stay ordered for every live flow.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.status == ST_NEW || res.status == ST_UPDATE) |->
		res.length_least <= res.length_most)
		else $error("length bounds out of order");

endmodule

bind flow_statistics_table fst_checker u_fst_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the flow statistics table. A directed table of
// packets covers drops, port masking, timestamp extremes and gap saturation.
// Random traffic follows, mixing fresh flows, repeats of known flows and
// broken headers until the table overflows. Every result item is checked
// against a flow ledger that is kept inside the bench.
// ----------------------------------------------------------------------------
module testbench import fst_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_SIZE   = 1024;
	localparam int RANDOM_ITEMS = 1250;
	localparam int IDLE_LIMIT   = 5000;
	localparam int HOLD_CYCLES  = 400;
	localparam int MAX_REPORTS  = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pkt_valid = 1'b0;
	logic pkt_stall;
	pkt_t pkt = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	always #2 clk = ~clk;

	flow_statistics_table #(.FLOW_ENTRIES(TABLE_SIZE)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.pkt_valid(pkt_valid),
		.pkt_stall(pkt_stall),
		.pkt(pkt),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	// The flow ledger: our own copy of the table, indexed by slot, with the
	// five-tuple key mapped to the slot it was given.
	int          slot_of[bit [103:0]];
	int          flows_used = 0;
	logic [51:0] last_seen[TABLE_SIZE];
	logic [31:0] pkt_count[TABLE_SIZE];
	logic [31:0] byte_count[TABLE_SIZE];
	logic [47:0] gap_total[TABLE_SIZE];
	logic [31:0] gap_low[TABLE_SIZE];
	logic [31:0] gap_high[TABLE_SIZE];
	logic [15:0] len_low[TABLE_SIZE];
	logic [15:0] len_high[TABLE_SIZE];

	res_t pending_records[$];
	pkt_t flow_book[$];

	int  errors = 0;
	int  idle_cycles = 0;
	int  hold_left = 0;
	bit  hold_request = 1'b0;
	bit  quiet = 1'b0;
	int  seen_status[4] = '{0, 0, 0, 0};
	logic [31:0] clock_seconds = 32'd1000;

	// Works out the record that the table returns for one packet, and applies
	// the same update to the ledger.
	function automatic res_t meter_packet(pkt_t p);
		res_t        r;
		logic [16:0] hdr;
		logic [15:0] l4;
		logic [15:0] sp;
		logic [15:0] dp;
		logic [103:0] key;
		logic [63:0] now64;
		logic [51:0] now;
		logic [63:0] gap;
		logic [48:0] sum;
		int          s;
		bit          fresh;
		r = '0;
		hdr = 17'(p.header_words) * 17'd4;
		if (p.captured_ip_size < MIN_IP_BYTES || hdr > 17'(p.captured_ip_size) ||
				p.total_length > p.captured_ip_size || p.fragment_offset != 0) begin
			r.status = ST_DROP;
			return r;
		end
		// The layer-4 length wraps when the header is longer than the packet.
		l4 = p.total_length - hdr[15:0];
		sp = p.source_port_raw;
		dp = p.dest_port_raw;
		if (!((p.ip_protocol == PROTO_TCP && l4 >= MIN_TCP_BYTES) ||
				(p.ip_protocol == PROTO_UDP && l4 >= MIN_UDP_BYTES))) begin
			sp = '0;
			dp = '0;
		end
		key = {p.source_address, p.dest_address, sp, dp, p.ip_protocol};
		now64 = 64'(p.stamp_seconds) * 64'(MICROS_PER_SECOND) + 64'(p.stamp_micros);
		now = now64[51:0];
		fresh = !slot_of.exists(key);
		if (fresh) begin
			if (flows_used >= TABLE_SIZE) begin
				r.status = ST_FULL;
				return r;
			end
			s = flows_used;
			flows_used++;
			slot_of[key] = s;
			last_seen[s] = now;
			pkt_count[s] = '0;
			byte_count[s] = '0;
			gap_total[s] = '0;
			gap_low[s] = GAP_START;
			gap_high[s] = '0;
			len_low[s] = p.frame_length;
			len_high[s] = p.frame_length;
		end else begin
			s = slot_of[key];
		end
		pkt_count[s] = pkt_count[s] + 32'd1;
		byte_count[s] = byte_count[s] + 32'(p.frame_length);
		// A timestamp that runs backward counts as a gap of zero.
		gap = (now >= last_seen[s]) ? 64'(now - last_seen[s]) : 64'd0;
		if (gap > 64'hFFFF_FFFF)
			gap = 64'hFFFF_FFFF;
		sum = 49'(gap_total[s]) + 49'(gap);
		gap_total[s] = sum[48] ? '1 : sum[47:0];
		if (!fresh) begin
			if (gap[31:0] < gap_low[s])
				gap_low[s] = gap[31:0];
			if (gap[31:0] > gap_high[s])
				gap_high[s] = gap[31:0];
		end
		if (p.frame_length < len_low[s])
			len_low[s] = p.frame_length;
		if (p.frame_length > len_high[s])
			len_high[s] = p.frame_length;
		last_seen[s] = now;
		r.status = fresh ? ST_NEW : ST_UPDATE;
		r.flow_slot = s[9:0];
		r.packet_total = pkt_count[s];
		r.byte_total = byte_count[s];
		r.gap_micros = gap[31:0];
		r.gap_sum = gap_total[s];
		r.gap_least = gap_low[s];
		r.gap_most = gap_high[s];
		r.length_least = len_low[s];
		r.length_most = len_high[s];
		return r;
	endfunction

	function automatic pkt_t make_pkt(logic [31:0] src, logic [31:0] dst,
			logic [15:0] sp, logic [15:0] dp, logic [7:0] proto, logic [3:0] hw,
			logic [15:0] tot, logic [12:0] frag, logic [15:0] cap,
			logic [31:0] secs, logic [19:0] us, logic [15:0] flen);
		pkt_t p;
		p = {src, dst, sp, dp, proto, hw, tot, frag, cap, secs, us, flen};
		return p;
	endfunction

	// Timestamps mostly move forward a little, but now and then jump to any
	// value, which also drives the out-of-range microseconds, or step back.
	function automatic pkt_t restamp(pkt_t p);
		int mode;
		mode = $urandom_range(0, 9);
		if (mode == 0) begin
			p.stamp_seconds = $urandom;
			p.stamp_micros = 20'($urandom_range(0, 1048575));
		end else if (mode == 1) begin
			p.stamp_seconds = clock_seconds - 32'd1;
			p.stamp_micros = 20'($urandom_range(0, 999999));
		end else begin
			clock_seconds = clock_seconds + 32'($urandom_range(0, 2));
			p.stamp_seconds = clock_seconds;
			p.stamp_micros = 20'($urandom_range(0, 999999));
		end
		p.frame_length = 16'($urandom_range(0, 65535));
		return p;
	endfunction

	function automatic pkt_t random_packet();
		pkt_t         p;
		logic [223:0] noise;
		int           pick;
		int           floor_cap;
		int           hw;
		pick = $urandom_range(0, 99);
		noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		p = noise[$bits(pkt_t)-1:0];
		if (pick < 8) begin
			// Broken header, one of the four ways to be dropped.
			case ($urandom_range(0, 3))
				0: p.captured_ip_size = 16'($urandom_range(0, 19));
				1: p.fragment_offset = 13'($urandom_range(1, 8191));
				2: begin
					p.captured_ip_size = 16'($urandom_range(20, 65534));
					p.total_length = 16'($urandom_range(p.captured_ip_size + 1, 65535));
				end
				default: begin
					hw = $urandom_range(6, 15);
					p.header_words = 4'(hw);
					p.captured_ip_size = 16'($urandom_range(20, hw * 4 - 1));
				end
			endcase
			return p;
		end
		if (pick < 14 && flow_book.size() > 0)
			return restamp(flow_book[$urandom_range(0, flow_book.size() - 1)]);
		p.fragment_offset = '0;
		hw = p.header_words;
		floor_cap = (hw * 4 > 20) ? hw * 4 : 20;
		p.captured_ip_size = 16'($urandom_range(floor_cap, 65535));
		p.total_length = 16'($urandom_range(0, p.captured_ip_size));
		case ($urandom_range(0, 4))
			0, 1: p.ip_protocol = PROTO_TCP;
			2, 3: p.ip_protocol = PROTO_UDP;
			default: ;
		endcase
		p = restamp(p);
		flow_book.push_back(p);
		return p;
	endfunction

	// Offers one item after a random gap and records its expected result once
	// the table takes it.
	task automatic offer(pkt_t p, bit fixed, res_t want);
		int   gap;
		res_t guess;
		gap = quiet ? 0 : $urandom_range(0, 14);
		@(negedge clk);
		if (gap > 0) begin
			pkt_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pkt <= p;
		pkt_valid <= 1'b1;
		@(posedge clk);
		while (pkt_stall)
			@(posedge clk);
		guess = meter_packet(p);
		pending_records.push_back(fixed ? want : guess);
	endtask

	task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
		if (want !== got) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	// The receiver stalls for a drawn number of cycles before each result.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			res_stall <= 1'b1;
			hold_left--;
		end else begin
			res_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (res_valid && !res_stall) begin
			if (pending_records.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected result item %0h", $time, res);
			end else begin
				want = pending_records.pop_front();
				check_field("status", 48'(want.status), 48'(res.status));
				check_field("flow_slot", 48'(want.flow_slot), 48'(res.flow_slot));
				check_field("packet_total", 48'(want.packet_total), 48'(res.packet_total));
				check_field("byte_total", 48'(want.byte_total), 48'(res.byte_total));
				check_field("gap_micros", 48'(want.gap_micros), 48'(res.gap_micros));
				check_field("gap_sum", want.gap_sum, res.gap_sum);
				check_field("gap_least", 48'(want.gap_least), 48'(res.gap_least));
				check_field("gap_most", 48'(want.gap_most), 48'(res.gap_most));
				check_field("length_least", 48'(want.length_least), 48'(res.length_least));
				check_field("length_most", 48'(want.length_most), 48'(res.length_most));
				seen_status[want.status]++;
			end
			hold_left = quiet ? 0 : $urandom_range(0, 14);
			// One long hold-off backs up the table's output so that it pushes back
			// on its input while the sender keeps offering.
			if (hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
		end
	end

	// The watchdog ends a run in which nothing moves for too long.
	always @(posedge clk) begin
		if ((pkt_valid && !pkt_stall) || (res_valid && !res_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout after %0d idle cycles", IDLE_LIMIT);
			$display("flow_statistics_table: mismatch");
			$finish;
		end
	end

	typedef struct {
		pkt_t p;
		bit   fixed;
		res_t want;
	} probe_t;

	probe_t probes[$];

	initial begin
		res_t dropped;
		res_t first_seen;
		res_t none;
		none = '0;
		dropped = '0;
		dropped.status = ST_DROP;
		first_seen = '0;
		first_seen.status = ST_NEW;
		first_seen.packet_total = 32'd1;
		first_seen.byte_total = 32'd65535;
		first_seen.gap_least = GAP_START;
		first_seen.length_least = 16'hFFFF;
		first_seen.length_most = 16'hFFFF;

		// Captured size below a bare IP header.
		probes.push_back('{make_pkt('1, '1, '1, '1, PROTO_TCP, 4'd5, 16'd19, '0, 16'd19,
			32'd5, 20'd0, 16'd64), 1'b1, dropped});
		// Header longer than the capture.
		probes.push_back('{make_pkt('1, '1, '1, '1, PROTO_TCP, 4'd15, 16'd40, '0, 16'd40,
			32'd5, 20'd0, 16'd64), 1'b1, dropped});
		// Total length beyond the capture.
		probes.push_back('{make_pkt('1, '1, '1, '1, PROTO_TCP, 4'd5, 16'hFFFF, '0,
			16'hFFFE, 32'd5, 20'd0, 16'd64), 1'b1, dropped});
		// A later fragment.
		probes.push_back('{make_pkt('1, '1, '1, '1, PROTO_TCP, 4'd5, 16'd40, 13'h1FFF,
			16'd40, 32'd5, 20'd0, 16'd64), 1'b1, dropped});
		// First TCP packet of a flow lands in slot zero.
		probes.push_back('{make_pkt('1, '1, '1, '1, PROTO_TCP, 4'd5, 16'd40, '0, 16'd40,
			32'd5, 20'd0, 16'hFFFF), 1'b1, first_seen});
		// The same flow one second later, then stepping back in time.
		probes.push_back('{make_pkt('1, '1, '1, '1, PROTO_TCP, 4'd5, 16'd40, '0, 16'd40,
			32'd6, 20'd0, 16'd0), 1'b0, none});
		probes.push_back('{make_pkt('1, '1, '1, '1, PROTO_TCP, 4'd5, 16'd40, '0, 16'd40,
			32'd5, 20'd999999, 16'd100), 1'b0, none});
		// A jump to the end of time saturates the gap.
		probes.push_back('{make_pkt('1, '1, '1, '1, PROTO_TCP, 4'd5, 16'd40, '0, 16'd40,
			'1, 20'hFFFFF, 16'd200), 1'b0, none});
		probes.push_back('{make_pkt('1, '1, '1, '1, PROTO_TCP, 4'd5, 16'd40, '0, 16'd40,
			32'd0, 20'd0, 16'd300), 1'b0, none});
		// UDP one byte short of its header: ports are dropped from the key.
		probes.push_back('{make_pkt(32'h0A000001, 32'h0A000002, 16'd53, 16'd53, PROTO_UDP,
			4'd5, 16'd27, '0, 16'd27, 32'd7, 20'd1, 16'd60), 1'b0, none});
		probes.push_back('{make_pkt(32'h0A000001, 32'h0A000002, 16'd99, 16'd7, PROTO_UDP,
			4'd5, 16'd27, '0, 16'd27, 32'd7, 20'd9, 16'd61), 1'b0, none});
		// UDP with exactly eight bytes keeps its ports.
		probes.push_back('{make_pkt(32'h0A000001, 32'h0A000002, 16'd53, 16'd53, PROTO_UDP,
			4'd5, 16'd28, '0, 16'd28, 32'd8, 20'd0, 16'd62), 1'b0, none});
		// TCP whose total length is shorter than its header: the wrapped
		// layer-4 length keeps the ports.
		probes.push_back('{make_pkt(32'h01020304, 32'h05060708, 16'h8000, 16'h0001,
			PROTO_TCP, 4'd5, 16'd10, '0, 16'd20, 32'd9, 20'd0, 16'd40), 1'b0, none});
		// TCP with 19 layer-4 bytes loses its ports.
		probes.push_back('{make_pkt(32'h01020304, 32'h05060708, 16'h8000, 16'h0001,
			PROTO_TCP, 4'd5, 16'd39, '0, 16'd39, 32'd9, 20'd5, 16'd40), 1'b0, none});
		// Another protocol never uses ports.
		probes.push_back('{make_pkt(32'h01020304, 32'h05060708, 16'h1234, 16'h5678,
			8'd1, 4'd5, 16'd84, '0, 16'd84, 32'd9, 20'd7, 16'd98), 1'b0, none});
		// All-zero header with the smallest capture that passes.
		probes.push_back('{make_pkt('0, '0, '0, '0, 8'd0, 4'd0, 16'd0, '0, 16'd20,
			'0, '0, '0), 1'b0, none});
		probes.push_back('{make_pkt('0, '0, '0, '0, 8'd0, 4'd0, 16'd0, '0, 16'hFFFF,
			'0, 20'd3, 16'hFFFF), 1'b0, none});
		// Protocol 255, largest header and capture.
		probes.push_back('{make_pkt(32'h80000000, 32'h00000001, '1, '0, 8'hFF, 4'd15,
			16'hFFFF, '0, 16'hFFFF, 32'h80000000, 20'd999999, 16'd1), 1'b0, none});

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (probes[i])
			offer(probes[i].p, probes[i].fixed, probes[i].want);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// Every fourth stretch of 150 items runs without any gaps.
			quiet = ((i / 150) % 4) == 3;
			if (i == 400)
				hold_request = 1'b1;
			offer(random_packet(), 1'b0, none);
		end
		@(negedge clk);
		pkt_valid <= 1'b0;

		while (pending_records.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d drops, %0d new flows, %0d updates, %0d full-table refusals",
			seen_status[ST_DROP], seen_status[ST_NEW], seen_status[ST_UPDATE],
			seen_status[ST_FULL]);
		if (errors == 0)
			$display("flow_statistics_table: match");
		else
			$display("flow_statistics_table: mismatch");
		$finish;
	end

endmodule

// ===== flow_statistics_table.f =====
rtl/fst_pkg.sv
rtl/fst_cell.sv
rtl/flow_statistics_table.sv
rtl/fst_checker.sv
tb/sv/testbench.sv
